/* sv/fffbt_pkg.sv */
// types and constants shared by the first-fit free block table
// no dependencies
`default_nettype none

package fffbt_pkg;

    localparam int START_W  = 48;
    localparam int LENGTH_W = 32;
    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_NOFIT = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    typedef enum logic {
        OP_ALLOCATE = 1'b0,
        OP_RELEASE  = 1'b1
    } op_t;

    typedef struct packed {
        logic [START_W-1:0]  start;
        logic [LENGTH_W-1:0] length;
    } entry_t;

endpackage

`default_nettype wire

/* sv/fffbt_ram.sv */
// entry memory of the free block table: one write port, one read port,
// registered read data; depends on fffbt_pkg
`default_nettype none

module fffbt_ram
    import fffbt_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire                       aclk,
    input  wire                       we,
    input  wire  [$clog2(DEPTH)-1:0]  waddr,
    input  entry_t                    wdata,
    input  wire                       re,
    input  wire  [$clog2(DEPTH)-1:0]  raddr,
    output entry_t                    rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/first_fit_free_block_table.sv */
// First-fit free block table. Free blocks (start, length) are kept sorted by
// start in a single-port-read entry memory, and the block handles one
// transaction at a time. An allocate walks the entries from the front one per
// cycle until entry k fits with room to spare or nothing fits (k = count-1);
// an exact fit closes the gap, and an empty table needs no walk. A release
// walks the table and shifts the entries behind its place, or goes at the
// end; an empty or full table needs no walk. The memory read port, one
// entry per cycle, sets the pace of these walks. A finished result waits in
// the output register while the next transaction is taken. No clearing pass
// is needed after reset.
// depends on fffbt_pkg and fffbt_ram
`default_nettype none

module first_fit_free_block_table
    import fffbt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [79:0] s_tdata,   // request_size [31:0], request_offset [79:32]
    input  wire         s_tuser,   // operation [0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata    // status [1:0], granted_offset [49:2], zero [55:50]
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = IW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ASCAN,
        S_AREMOVE,
        S_RSCAN,
        S_RTAIL,
        S_POST
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [IW-1:0]        idx_reg, idx_next;
    op_t                  op_reg, op_next;
    logic [LENGTH_W-1:0]  size_reg, size_next;
    logic [START_W-1:0]   offset_reg, offset_next;
    entry_t               carry_reg, carry_next;
    logic                 inserted_reg, inserted_next;
    status_t              res_status_reg, res_status_next;
    logic [START_W-1:0]   res_offset_reg, res_offset_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [55:0]          m_tdata_reg, m_tdata_next;

    logic                 we, re;
    logic [IW-1:0]        waddr, raddr;
    entry_t               wdata, rdata, new_entry;
    logic [CW-1:0]        idx_inc;
    logic                 more, out_free;

    fffbt_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign idx_inc   = {1'b0, idx_reg} + CW'(1);
    assign more      = idx_inc < count_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign new_entry = '{start: offset_reg, length: size_reg};

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        size_next       = size_reg;
        offset_next     = offset_reg;
        carry_next      = carry_reg;
        inserted_next   = inserted_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        we              = 1'b0;
        waddr           = idx_reg;
        wdata           = carry_reg;
        re              = 1'b0;
        raddr           = idx_inc[IW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next         = op_t'(s_tuser);
                    size_next       = s_tdata[31:0];
                    offset_next     = s_tdata[79:32];
                    idx_next        = '0;
                    inserted_next   = 1'b0;
                    res_status_next = STATUS_OK;
                    res_offset_next = '0;
                    if (op_t'(s_tuser) == OP_ALLOCATE) begin
                        if (count_reg == '0) begin
                            res_status_next = STATUS_NOFIT;
                            state_next      = S_POST;
                        end else begin
                            re         = 1'b1;
                            raddr      = '0;
                            state_next = S_ASCAN;
                        end
                    end else begin
                        if (count_reg == CW'(TABLE_DEPTH)) begin
                            res_status_next = STATUS_FULL;
                            state_next      = S_POST;
                        end else if (count_reg == '0) begin
                            we         = 1'b1;
                            waddr      = '0;
                            wdata      = '{start: s_tdata[79:32], length: s_tdata[31:0]};
                            count_next = count_reg + CW'(1);
                            state_next = S_POST;
                        end else begin
                            re         = 1'b1;
                            raddr      = '0;
                            state_next = S_RSCAN;
                        end
                    end
                end
            end
            S_ASCAN: begin
                re = more;
                if (rdata.length >= size_reg) begin
                    res_offset_next = rdata.start;
                    if (rdata.length > size_reg) begin
                        we         = 1'b1;
                        wdata      = '{start:  rdata.start + START_W'(size_reg),
                                       length: rdata.length - size_reg};
                        state_next = S_POST;
                    end else if (more) begin
                        idx_next   = idx_inc[IW-1:0];
                        state_next = S_AREMOVE;
                    end else begin
                        count_next = count_reg - CW'(1);
                        state_next = S_POST;
                    end
                end else if (more) begin
                    idx_next = idx_inc[IW-1:0];
                end else begin
                    res_status_next = STATUS_NOFIT;
                    state_next      = S_POST;
                end
            end
            S_AREMOVE: begin
                re    = more;
                we    = 1'b1;
                waddr = idx_reg - IW'(1);
                wdata = rdata;
                if (more) begin
                    idx_next = idx_inc[IW-1:0];
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = S_POST;
                end
            end
            S_RSCAN: begin
                re = more;
                if (inserted_reg || rdata.start >= offset_reg) begin
                    we            = 1'b1;
                    wdata         = inserted_reg ? carry_reg : new_entry;
                    carry_next    = rdata;
                    inserted_next = 1'b1;
                    if (more) begin
                        idx_next = idx_inc[IW-1:0];
                    end else begin
                        state_next = S_RTAIL;
                    end
                end else if (more) begin
                    idx_next = idx_inc[IW-1:0];
                end else begin
                    we         = 1'b1;
                    waddr      = count_reg[IW-1:0];
                    wdata      = new_entry;
                    count_next = count_reg + CW'(1);
                    state_next = S_POST;
                end
            end
            S_RTAIL: begin
                we         = 1'b1;
                waddr      = count_reg[IW-1:0];
                wdata      = carry_reg;
                count_next = count_reg + CW'(1);
                state_next = S_POST;
            end
            S_POST: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, res_offset_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        idx_reg        <= idx_next;
        op_reg         <= op_next;
        size_reg       <= size_next;
        offset_reg     <= offset_next;
        carry_reg      <= carry_next;
        inserted_reg   <= inserted_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* sv/fffbt_checker.sv */
// port-level checks for the first-fit free block table, bound to the top level
// depends on fffbt_pkg and first_fit_free_block_table
`default_nettype none

module fffbt_checker
    import fffbt_pkg::*;
(
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire  [55:0] m_tdata
);

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one transaction in flight at a time
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == STATUS_OK || m_tdata[1:0] == STATUS_NOFIT
                      || m_tdata[1:0] == STATUS_FULL) && m_tdata[55:50] == 6'd0)
        else $error("bad status code or padding");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != STATUS_OK |-> m_tdata[49:2] == 48'd0)
        else $error("offset given with failure status");

endmodule

bind first_fit_free_block_table fffbt_checker u_fffbt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
